### rtl/rodf_pkg.sv
// Shared types and constants for the rectangle outline distance field block
package rodf_pkg;

  localparam int COORD_W  = 6;
  localparam int DELTA_W  = COORD_W + 1;
  localparam int D2_W     = 13;
  localparam int ROOT_W   = 16;
  localparam int PROD_W   = ROOT_W + D2_W;
  localparam int RES_W    = 48;
  localparam int NUM_SEG  = 4;
  localparam int NUM_LANE = 3;
  localparam int DATA_W   = 16;
  localparam int ADDR_W   = 4;
  localparam int PDATA_W  = 32;
  localparam int DEF_GRID_SIZE = 64;

  // Scale shifts: unit lanes use (2^15 * a)^2, distance lane uses 2^18 * d2
  localparam int UNIT_SHIFT = 30;
  localparam int DIST_SHIFT = 18;

  localparam logic [DATA_W-1:0] Q14_ONE  = 16'h4000;
  localparam logic [DATA_W-1:0] ON_DIST  = 16'd205;
  localparam logic [DATA_W-1:0] DIST_MAX = 16'hFFFF;

  localparam logic [COORD_W-1:0] RST_TOP    = 6'd24;
  localparam logic [COORD_W-1:0] RST_LEFT   = 6'd19;
  localparam logic [COORD_W-1:0] RST_BOTTOM = 6'd40;
  localparam logic [COORD_W-1:0] RST_RIGHT  = 6'd45;

  typedef enum logic [1:0] {
    REG_TOP    = 2'd0,
    REG_LEFT   = 2'd1,
    REG_BOTTOM = 2'd2,
    REG_RIGHT  = 2'd3
  } reg_idx_t;

  typedef logic signed [1:0] code_t;
  localparam code_t CODE_POS  = 2'sb01;
  localparam code_t CODE_ZERO = 2'sb00;
  localparam code_t CODE_NEG  = 2'sb11;

  typedef struct packed {
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] bottom;
    logic [COORD_W-1:0] right;
  } rect_t;

  typedef struct packed {
    logic                      ok;
    logic signed [DELTA_W-1:0] dr;
    logic signed [DELTA_W-1:0] dc;
    code_t                     cx;
    code_t                     cy;
  } seg_t;

  typedef struct packed {
    logic                      ok;
    logic [D2_W-1:0]           d2;
    logic signed [DELTA_W-1:0] dr;
    logic signed [DELTA_W-1:0] dc;
    code_t                     cx;
    code_t                     cy;
  } segd_t;

  typedef struct packed {
    logic  empty;
    logic  on;
    logic  neg_x;
    logic  neg_y;
    code_t cx;
    code_t cy;
  } side_t;

endpackage

### rtl/rodf_if.sv
// Valid/ready channel interfaces for pixel words and result words
interface rodf_in_if import rodf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] pixel_row;
  logic [COORD_W-1:0] pixel_col;

  modport source (output valid, pixel_row, pixel_col, input ready);
  modport sink   (input valid, pixel_row, pixel_col, output ready);
endinterface

interface rodf_out_if import rodf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] unit_x;
  logic signed [DATA_W-1:0] unit_y;
  logic [DATA_W-1:0]        dist_px;
  logic                     on_outline;

  modport source (output valid, unit_x, unit_y, dist_px, on_outline, input ready);
  modport sink   (input valid, unit_x, unit_y, dist_px, on_outline, output ready);
endinterface

### rtl/rodf_nearest.sv
// Three-stage search for the nearest outline point in walk order
module rodf_nearest import rodf_pkg::*; #(
  parameter int GRID_SIZE = DEF_GRID_SIZE
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [COORD_W-1:0] pixel_row,
  input  logic [COORD_W-1:0] pixel_col,
  input  rect_t              rect,
  output logic               out_valid,
  output segd_t              best
);

  localparam int CMAX_I = (GRID_SIZE - 1 > (2**COORD_W) - 1) ? (2**COORD_W) - 1 : GRID_SIZE - 1;
  localparam logic [COORD_W-1:0] CMAX = COORD_W'(CMAX_I);

  function automatic logic signed [DELTA_W-1:0] grid(input logic [COORD_W-1:0] v);
    logic [COORD_W-1:0] c;
    c = (v > CMAX) ? CMAX : v;
    return signed'({1'b0, c});
  endfunction

  function automatic logic signed [DELTA_W-1:0] lim(input logic signed [DELTA_W-1:0] v,
                                                    input logic signed [DELTA_W-1:0] lo,
                                                    input logic signed [DELTA_W-1:0] hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  logic signed [DELTA_W-1:0] t0, b0, l0, r0, t, b, l, r, qr, qc;
  logic signed [DELTA_W-1:0] x0, y1, x2, y3;
  seg_t  seg_in [NUM_SEG];
  seg_t  s1_seg [NUM_SEG];
  segd_t s2_seg [NUM_SEG];
  segd_t best_next;
  logic  s1_valid, s2_valid;

  // Sort the rectangle and project the pixel onto each edge
  always_comb begin
    t0 = grid(rect.top);
    b0 = grid(rect.bottom);
    l0 = grid(rect.left);
    r0 = grid(rect.right);
    t  = (t0 > b0) ? b0 : t0;
    b  = (t0 > b0) ? t0 : b0;
    l  = (l0 > r0) ? r0 : l0;
    r  = (l0 > r0) ? l0 : r0;
    qr = grid(pixel_row);
    qc = grid(pixel_col);

    x0 = lim(qc, l, r - 7'sd1);
    y1 = lim(qr, t, b - 7'sd1);
    x2 = lim(qc, l + 7'sd1, r);
    y3 = lim(qr, t + 7'sd1, b);

    // top edge, from the left corner
    seg_in[0].ok = (l < r);
    seg_in[0].dr = qr - t;
    seg_in[0].dc = qc - x0;
    seg_in[0].cx = (x0 == l) ? CODE_NEG : CODE_ZERO;
    seg_in[0].cy = CODE_POS;
    // right edge, from the top corner
    seg_in[1].ok = (t < b);
    seg_in[1].dr = qr - y1;
    seg_in[1].dc = qc - r;
    seg_in[1].cx = CODE_POS;
    seg_in[1].cy = (y1 == t) ? CODE_POS : CODE_ZERO;
    // bottom edge, from the right corner
    seg_in[2].ok = (l < r);
    seg_in[2].dr = qr - b;
    seg_in[2].dc = qc - x2;
    seg_in[2].cx = (x2 == r) ? CODE_POS : CODE_ZERO;
    seg_in[2].cy = CODE_NEG;
    // left edge, from the bottom corner
    seg_in[3].ok = (t < b);
    seg_in[3].dr = qr - y3;
    seg_in[3].dc = qc - l;
    seg_in[3].cx = CODE_NEG;
    seg_in[3].cy = (y3 == b) ? CODE_NEG : CODE_ZERO;
  end

  // Stage 1: edge candidates
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
    if (en) begin
      s1_seg <= seg_in;
    end
  end

  // Stage 2: squared distance per candidate
  always_ff @(posedge clk) begin
    logic signed [2*DELTA_W-1:0] sr, sc;
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
    if (en) begin
      for (int i = 0; i < NUM_SEG; i++) begin
        sr = s1_seg[i].dr * s1_seg[i].dr;
        sc = s1_seg[i].dc * s1_seg[i].dc;
        s2_seg[i].ok <= s1_seg[i].ok;
        s2_seg[i].d2 <= D2_W'(sr) + D2_W'(sc);
        s2_seg[i].dr <= s1_seg[i].dr;
        s2_seg[i].dc <= s1_seg[i].dc;
        s2_seg[i].cx <= s1_seg[i].cx;
        s2_seg[i].cy <= s1_seg[i].cy;
      end
    end
  end

  // Keep the first strictly smaller candidate in walk order
  always_comb begin
    best_next = s2_seg[0];
    for (int i = 1; i < NUM_SEG; i++) begin
      if (s2_seg[i].ok && (!best_next.ok || s2_seg[i].d2 < best_next.d2)) begin
        best_next = s2_seg[i];
      end
    end
  end

  // Stage 3: winning candidate
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s2_valid;
    end
    if (en) begin
      best <= best_next;
    end
  end

endmodule

### rtl/rodf_root.sv
// Pipelined scaled square root: largest m with m*m*wt <= num, one bit per stage
module rodf_root import rodf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [RES_W-1:0]  num  [NUM_LANE],
  input  logic [D2_W-1:0]   wt   [NUM_LANE],
  input  side_t             in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] root [NUM_LANE],
  output side_t             out_side
);

  logic [RES_W-1:0]  rem_q  [ROOT_W][NUM_LANE];
  logic [PROD_W-1:0] prod_q [ROOT_W][NUM_LANE];
  logic [ROOT_W-1:0] root_q [ROOT_W][NUM_LANE];
  logic [D2_W-1:0]   wt_q   [ROOT_W][NUM_LANE];
  logic              vld_q  [ROOT_W];
  side_t             side_q [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    localparam int K = ROOT_W - 1 - s;

    logic [RES_W-1:0]  rem_i  [NUM_LANE];
    logic [PROD_W-1:0] prod_i [NUM_LANE];
    logic [ROOT_W-1:0] root_i [NUM_LANE];
    logic [D2_W-1:0]   wt_i   [NUM_LANE];
    logic              vld_i;
    side_t             side_i;
    logic [RES_W-1:0]  rem_n  [NUM_LANE];
    logic [PROD_W-1:0] prod_n [NUM_LANE];
    logic [ROOT_W-1:0] root_n [NUM_LANE];

    // Take the previous stage, or the unit input at the first stage
    if (s == 0) begin : g_first
      always_comb begin
        for (int i = 0; i < NUM_LANE; i++) begin
          rem_i[i]  = num[i];
          prod_i[i] = '0;
          root_i[i] = '0;
          wt_i[i]   = wt[i];
        end
        vld_i  = in_valid;
        side_i = in_side;
      end
    end else begin : g_next
      always_comb begin
        for (int i = 0; i < NUM_LANE; i++) begin
          rem_i[i]  = rem_q[s-1][i];
          prod_i[i] = prod_q[s-1][i];
          root_i[i] = root_q[s-1][i];
          wt_i[i]   = wt_q[s-1][i];
        end
        vld_i  = vld_q[s-1];
        side_i = side_q[s-1];
      end
    end

    // Try setting bit K: cost is 2^(K+1)*m*wt + 2^(2K)*wt
    always_comb begin
      logic [RES_W-1:0] d;
      for (int i = 0; i < NUM_LANE; i++) begin
        d = (RES_W'(prod_i[i]) << (K + 1)) + (RES_W'(wt_i[i]) << (2 * K));
        if (d <= rem_i[i]) begin
          rem_n[i]  = rem_i[i] - d;
          prod_n[i] = prod_i[i] + (PROD_W'(wt_i[i]) << K);
          root_n[i] = root_i[i] | (ROOT_W'(1) << K);
        end else begin
          rem_n[i]  = rem_i[i];
          prod_n[i] = prod_i[i];
          root_n[i] = root_i[i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else if (en) begin
        vld_q[s] <= vld_i;
      end
      if (en) begin
        rem_q[s]  <= rem_n;
        prod_q[s] <= prod_n;
        root_q[s] <= root_n;
        wt_q[s]   <= wt_i;
        side_q[s] <= side_i;
      end
    end
  end

  assign out_valid = vld_q[ROOT_W-1];
  assign root      = root_q[ROOT_W-1];
  assign out_side  = side_q[ROOT_W-1];

endmodule

### rtl/rect_outline_distance_field.sv
// An accepted pixel word passes through the nearest-point search, the square root and the output word register.
// Throughput: one pixel word per cycle; a stalled output freezes the whole pipeline.
// The 16-stage square root unit (one result bit per stage) sets the latency.
// Reset (rst, synchronous): empties the pipeline and loads the rectangle
// registers with top 24, left 19, bottom 40, right 45.
module rect_outline_distance_field import rodf_pkg::*; #(
  parameter int GRID_SIZE = DEF_GRID_SIZE
) (
  input  logic               clk,
  input  logic               rst,
  rodf_in_if.sink            in_ch,
  rodf_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  rect_t             rect;
  logic              en;
  logic              near_valid;
  segd_t             best;
  logic [RES_W-1:0]  num  [NUM_LANE];
  logic [D2_W-1:0]   wt   [NUM_LANE];
  side_t             side_in, side_out;
  logic              root_valid;
  logic [ROOT_W-1:0] root [NUM_LANE];
  logic [COORD_W-1:0] ax, ay;
  logic [ROOT_W:0]   qx, qy, qd;
  logic signed [DATA_W-1:0] ux_next, uy_next;
  logic [DATA_W-1:0] dist_next;
  logic              on_next;
  reg_idx_t          reg_sel;

  // Register file write and readback
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      rect.top    <= RST_TOP;
      rect.left   <= RST_LEFT;
      rect.bottom <= RST_BOTTOM;
      rect.right  <= RST_RIGHT;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_TOP:    rect.top    <= pwdata[COORD_W-1:0];
        REG_LEFT:   rect.left   <= pwdata[COORD_W-1:0];
        REG_BOTTOM: rect.bottom <= pwdata[COORD_W-1:0];
        REG_RIGHT:  rect.right  <= pwdata[COORD_W-1:0];
        default:    rect.top    <= rect.top;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_TOP:    prdata = PDATA_W'(rect.top);
      REG_LEFT:   prdata = PDATA_W'(rect.left);
      REG_BOTTOM: prdata = PDATA_W'(rect.bottom);
      REG_RIGHT:  prdata = PDATA_W'(rect.right);
      default:    prdata = '0;
    endcase
  end

  // Advance every stage unless a finished word waits
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  rodf_nearest #(
    .GRID_SIZE (GRID_SIZE)
  ) u_nearest (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_ch.valid),
    .pixel_row (in_ch.pixel_row),
    .pixel_col (in_ch.pixel_col),
    .rect      (rect),
    .out_valid (near_valid),
    .best      (best)
  );

  // Build root operands: two unit lanes and one distance lane
  always_comb begin
    ax = best.dc[DELTA_W-1] ? COORD_W'(-best.dc) : COORD_W'(best.dc);
    ay = best.dr[DELTA_W-1] ? COORD_W'(-best.dr) : COORD_W'(best.dr);
    num[0] = RES_W'(ax * ax) << UNIT_SHIFT;
    num[1] = RES_W'(ay * ay) << UNIT_SHIFT;
    num[2] = RES_W'(best.d2) << DIST_SHIFT;
    wt[0]  = best.d2;
    wt[1]  = best.d2;
    wt[2]  = D2_W'(1);
    side_in.empty = !best.ok;
    side_in.on    = (best.d2 == '0);
    side_in.neg_x = best.dc[DELTA_W-1];
    side_in.neg_y = (best.dr > 0);
    side_in.cx    = best.cx;
    side_in.cy    = best.cy;
  end

  rodf_root u_root (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (near_valid),
    .num       (num),
    .wt        (wt),
    .in_side   (side_in),
    .out_valid (root_valid),
    .root      (root),
    .out_side  (side_out)
  );

  function automatic logic signed [DATA_W-1:0] code_val(input code_t c);
    logic signed [DATA_W-1:0] v;
    case (c)
      CODE_POS: v = signed'(Q14_ONE);
      CODE_NEG: v = -signed'(Q14_ONE);
      default:  v = '0;
    endcase
    return v;
  endfunction

  // Round half up from the floor root, then apply the sign, the outline code or the empty result
  always_comb begin
    qx = ((ROOT_W + 1)'(root[0]) + 1'b1) >> 1;
    qy = ((ROOT_W + 1)'(root[1]) + 1'b1) >> 1;
    qd = ((ROOT_W + 1)'(root[2]) + 1'b1) >> 1;
    if (side_out.empty) begin
      ux_next   = '0;
      uy_next   = '0;
      dist_next = DIST_MAX;
      on_next   = 1'b0;
    end else if (side_out.on) begin
      ux_next   = code_val(side_out.cx);
      uy_next   = code_val(side_out.cy);
      dist_next = ON_DIST;
      on_next   = 1'b1;
    end else begin
      ux_next   = side_out.neg_x ? -signed'(DATA_W'(qx)) : signed'(DATA_W'(qx));
      uy_next   = side_out.neg_y ? -signed'(DATA_W'(qy)) : signed'(DATA_W'(qy));
      dist_next = DATA_W'(qd);
      on_next   = 1'b0;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (en) begin
      out_ch.valid <= root_valid;
    end
    if (en) begin
      out_ch.unit_x     <= ux_next;
      out_ch.unit_y     <= uy_next;
      out_ch.dist_px    <= dist_next;
      out_ch.on_outline <= on_next;
    end
  end

endmodule

### bench/rect_outline_distance_field_tb.sv
// Self-checking testbench for the rectangle outline distance field block
module rect_outline_distance_field_tb;
  import rodf_pkg::*;

  typedef struct {
    logic signed [DATA_W-1:0] unit_x;
    logic signed [DATA_W-1:0] unit_y;
    logic [DATA_W-1:0]        dist_px;
    logic                     on_outline;
  } field_word_t;

  typedef struct {
    int    row;
    int    col;
    code_t cx;
    code_t cy;
  } walk_pt_t;

  // Scoreboard: predicts the outline distance word and matches result words
  class outline_scoreboard;
    rect_t       rect;
    field_word_t field_q[$];
    int          errors;
    int          pixels_in;
    int          words_out;
    int          outline_hits;

    function new();
      rect   = '{top: RST_TOP, left: RST_LEFT, bottom: RST_BOTTOM, right: RST_RIGHT};
      errors = 0;
    endfunction

    // largest q in [0, hi] with (2q-1)^2 * den <= num
    function automatic longint unsigned round_root(longint unsigned num,
                                                   longint unsigned den,
                                                   longint unsigned hi);
      longint unsigned lo, mid, t;
      lo = 0;
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        t   = 2 * mid - 1;
        if (t * t * den <= num) lo = mid;
        else hi = mid - 1;
      end
      return lo;
    endfunction

    function automatic logic signed [DATA_W-1:0] unit_of(int v, longint unsigned d2);
      longint unsigned a, n, q;
      a = (v < 0) ? -v : v;
      n = 2 * 16384 * a;
      q = round_root(n * n, d2, 16384);
      return (v < 0) ? -$signed(q[DATA_W-1:0]) : $signed(q[DATA_W-1:0]);
    endfunction

    function automatic field_word_t nearest_outline(int prow, int pcol);
      field_word_t     w;
      walk_pt_t        pts[$];
      int              t, b, l, r, x, dr, dc, bdr, bdc;
      longint unsigned d2, bd2, root_d;
      bit              found;
      code_t           bcx, bcy;
      t = rect.top; b = rect.bottom; l = rect.left; r = rect.right;
      if (t > b) begin x = t; t = b; b = x; end
      if (l > r) begin x = l; l = r; r = x; end
      // clockwise walk: each edge holds its start corner only
      for (x = l; x < r; x++) pts.push_back('{t, x, (x == l) ? CODE_NEG : CODE_ZERO, CODE_POS});
      for (x = t; x < b; x++) pts.push_back('{x, r, CODE_POS, (x == t) ? CODE_POS : CODE_ZERO});
      for (x = r; x > l; x--) pts.push_back('{b, x, (x == r) ? CODE_POS : CODE_ZERO, CODE_NEG});
      for (x = b; x > t; x--) pts.push_back('{x, l, CODE_NEG, (x == b) ? CODE_NEG : CODE_ZERO});
      found = 0; bd2 = 0; bdr = 0; bdc = 0; bcx = CODE_ZERO; bcy = CODE_ZERO;
      foreach (pts[i]) begin
        dr = prow - pts[i].row;
        dc = pcol - pts[i].col;
        d2 = dr * dr + dc * dc;
        if (!found || d2 < bd2) begin
          found = 1; bd2 = d2; bdr = dr; bdc = dc; bcx = pts[i].cx; bcy = pts[i].cy;
        end
      end
      w.on_outline = 0;
      if (!found) begin
        w.unit_x = '0; w.unit_y = '0; w.dist_px = DIST_MAX;
      end else if (bd2 == 0) begin
        w.unit_x     = DATA_W'(bcx * 16384);
        w.unit_y     = DATA_W'(bcy * 16384);
        w.dist_px    = ON_DIST;
        w.on_outline = 1;
      end else begin
        w.unit_x = unit_of(bdc, bd2);
        w.unit_y = unit_of(-bdr, bd2);
        root_d   = round_root(bd2 * 262144, 1, 131071);
        w.dist_px = (root_d > 65535) ? DIST_MAX : root_d[DATA_W-1:0];
      end
      return w;
    endfunction

    function void note_pixel(logic [COORD_W-1:0] prow, logic [COORD_W-1:0] pcol);
      field_q.push_back(nearest_outline(prow, pcol));
      pixels_in++;
    endfunction

    function void check_word(logic signed [DATA_W-1:0] ux, logic signed [DATA_W-1:0] uy,
                             logic [DATA_W-1:0] dist_px, logic on);
      field_word_t e;
      words_out++;
      if (field_q.size() == 0) begin
        $error("result word with no pending pixel");
        errors++;
        return;
      end
      e = field_q.pop_front();
      if (e.on_outline) outline_hits++;
      if (ux !== e.unit_x) begin
        $error("unit_x expected %0d actual %0d", e.unit_x, ux); errors++;
      end
      if (uy !== e.unit_y) begin
        $error("unit_y expected %0d actual %0d", e.unit_y, uy); errors++;
      end
      if (dist_px !== e.dist_px) begin
        $error("dist_px expected %0d actual %0d", e.dist_px, dist_px); errors++;
      end
      if (on !== e.on_outline) begin
        $error("on_outline expected %0d actual %0d", e.on_outline, on); errors++;
      end
    endfunction
  endclass

  localparam int IDLE_LIMIT = 3000;
  localparam int LONG_HOLD  = 200;
  localparam int DRAIN_WAIT = 30;
  localparam int PHASE_PIX  = 130;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0] pwdata, prdata;
  logic pready;

  rodf_in_if  in_ch ();
  rodf_out_if out_ch ();

  outline_scoreboard sb;
  bit hold_req;
  bit quiet_rx;
  int idle_cycles;

  rect_outline_distance_field u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Note accepted pixel words and check accepted result words
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) sb.note_pixel(in_ch.pixel_row, in_ch.pixel_col);
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_word(out_ch.unit_x, out_ch.unit_y, out_ch.dist_px, out_ch.on_outline);
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Drive result ready with random stalls and one long hold-off on request
  initial begin
    int k;
    out_ch.ready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      k = $urandom_range(0, 99);
      if (hold_req) begin
        hold_req = 0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (quiet_rx || k < 70) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat ((k < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clk);
      end
    end
  end

  task automatic send_pixel(int prow, int pcol);
    int k;
    in_ch.valid     <= 1'b1;
    in_ch.pixel_row <= COORD_W'(prow);
    in_ch.pixel_col <= COORD_W'(pcol);
    @(posedge clk iff in_ch.ready);
    k = $urandom_range(0, 99);
    if (k >= 60) begin
      in_ch.valid <= 1'b0;
      repeat ((k < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.field_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, int val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * idx);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk iff pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_TOP:    sb.rect.top    = COORD_W'(val);
      REG_LEFT:   sb.rect.left   = COORD_W'(val);
      REG_BOTTOM: sb.rect.bottom = COORD_W'(val);
      REG_RIGHT:  sb.rect.right  = COORD_W'(val);
      default: ;
    endcase
  endtask

  task automatic set_rect(int t, int l, int b, int r);
    drain();
    write_reg(REG_TOP, t);
    write_reg(REG_LEFT, l);
    write_reg(REG_BOTTOM, b);
    write_reg(REG_RIGHT, r);
  endtask

  // Random pixels, half of them pulled onto the outline rows or columns
  task automatic random_pixels(int n, bit pause_mid);
    int prow, pcol;
    for (int i = 0; i < n; i++) begin
      if (pause_mid && i == n / 2) drain();
      prow = $urandom_range(0, 63);
      pcol = $urandom_range(0, 63);
      case ($urandom_range(0, 3))
        0: prow = $urandom_range(0, 1) ? sb.rect.top : sb.rect.bottom;
        1: pcol = $urandom_range(0, 1) ? sb.rect.left : sb.rect.right;
        default: ;
      endcase
      send_pixel(prow, pcol);
    end
  endtask

  initial begin
    int rects[8][4];
    sb = new();
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_ch.valid = 1'b0; in_ch.pixel_row = '0; in_ch.pixel_col = '0;
    hold_req = 0; quiet_rx = 0; idle_cycles = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: corners, edges, tie at center, grid extremes on the reset rectangle
    send_pixel(24, 19); send_pixel(24, 30); send_pixel(24, 45); send_pixel(30, 45);
    send_pixel(40, 45); send_pixel(40, 30); send_pixel(40, 19); send_pixel(30, 19);
    send_pixel(32, 32); send_pixel(0, 0);   send_pixel(63, 63); send_pixel(0, 63);
    send_pixel(63, 0);  send_pixel(10, 30); send_pixel(50, 50); send_pixel(25, 20);

    // Fill the pipeline while the receiver holds off
    hold_req = 1;
    random_pixels(PHASE_PIX, 0);

    // Full grid, swapped, flat, empty and tiny rectangles
    rects = '{'{0, 0, 63, 63}, '{50, 60, 10, 5}, '{20, 5, 20, 50}, '{5, 30, 55, 30},
              '{33, 33, 33, 33}, '{63, 0, 0, 63}, '{10, 10, 11, 11}, '{0, 63, 63, 0}};
    foreach (rects[p]) begin
      set_rect(rects[p][0], rects[p][1], rects[p][2], rects[p][3]);
      quiet_rx = (p == 2);
      if (rects[p][0] == 0 && rects[p][1] == 0) begin
        send_pixel(0, 0); send_pixel(63, 63); send_pixel(0, 63); send_pixel(63, 0);
      end
      random_pixels((p == 4) ? 40 : PHASE_PIX, p == 1);
    end
    quiet_rx = 0;
    repeat (2) begin
      set_rect($urandom_range(0, 63), $urandom_range(0, 63),
               $urandom_range(0, 63), $urandom_range(0, 63));
      random_pixels(PHASE_PIX, 0);
    end

    drain();
    $display("Checked %0d pixel words, %0d on the outline, over 11 rectangle settings",
             sb.pixels_in, sb.outline_hits);
    if (sb.errors == 0 && sb.field_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
